// File: rtl/setm_pkg.sv
// Shared types and constants for the sensor event timing monitor.
// Used by the controller, the datapath and the top level; depends on nothing.
package setm_pkg;

  localparam int MODE_W     = 3;
  localparam int TYPE_W     = 6;
  localparam int STAMP_W    = 64;
  localparam int CNT_W      = 32;
  localparam int HALF_W     = 32;
  localparam int S_TDATA_W  = 136;
  localparam int M_TDATA_W  = 384;
  localparam int M_TUSER_W  = 2;

  localparam logic [STAMP_W-1:0] ALL_ONES = {STAMP_W{1'b1}};

  // Item modes.
  localparam logic [MODE_W-1:0] MODE_LOAD   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_COMM   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_JITTER = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ORDER  = 3'd4;

  // Statistics kept for one sensor type.
  typedef struct packed {
    logic [STAMP_W-1:0] prev_stamp;
    logic [STAMP_W-1:0] period;
    logic [STAMP_W-1:0] min_dev;
    logic [STAMP_W-1:0] max_dev;
    logic [STAMP_W-1:0] square_sum;
    logic [CNT_W-1:0]   event_count;
    logic [CNT_W-1:0]   order_count;
    logic [CNT_W-1:0]   order_fails;
    logic [STAMP_W-1:0] last_reversed;
    logic [CNT_W-1:0]   comm_count;
  } stat_rec_t;

  localparam stat_rec_t REC_RESET = '{
    prev_stamp:    '0,
    period:        '0,
    min_dev:       ALL_ONES,
    max_dev:       '0,
    square_sum:    '0,
    event_count:   '0,
    order_count:   '0,
    order_fails:   '0,
    last_reversed: '0,
    comm_count:    '0
  };

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic lookup;
    logic deviate;
    logic mul_lo;
    logic mul_hi;
    logic sq_sum;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic jitter_math;
    logic out_free;
  } status_t;

endpackage

// File: rtl/setm_ctrl.sv
// Sequencer of the sensor event timing monitor.
// Depends on setm_pkg for the command and status structs.
module setm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  setm_pkg::status_t status,
  output setm_pkg::cmd_t    cmd
);
  import setm_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_LOOKUP  = 7'b0000010,
    S_DEVIATE = 7'b0000100,
    S_SQ_LO   = 7'b0001000,
    S_SQ_HI   = 7'b0010000,
    S_SQ_SUM  = 7'b0100000,
    S_COMMIT  = 7'b1000000
  } state_t;

  state_t state, state_next;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (s_tvalid) state_next = S_LOOKUP;
      S_LOOKUP:  state_next = status.jitter_math ? S_DEVIATE : S_COMMIT;
      S_DEVIATE: state_next = S_SQ_LO;
      S_SQ_LO:   state_next = S_SQ_HI;
      S_SQ_HI:   state_next = S_SQ_SUM;
      S_SQ_SUM:  state_next = S_COMMIT;
      S_COMMIT:  if (status.out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Commands decoded from the state.
  assign s_tready     = (state == S_IDLE);
  assign cmd.capture  = (state == S_IDLE) && s_tvalid;
  assign cmd.lookup   = (state == S_LOOKUP);
  assign cmd.deviate  = (state == S_DEVIATE);
  assign cmd.mul_lo   = (state == S_SQ_LO);
  assign cmd.mul_hi   = (state == S_SQ_HI);
  assign cmd.sq_sum   = (state == S_SQ_SUM);
  assign cmd.commit   = (state == S_COMMIT) && status.out_free;

endmodule

// File: rtl/setm_dp.sv
// Datapath of the sensor event timing monitor: per-type statistics memory,
// deviation and square unit, update logic and output register. Uses setm_pkg.
module setm_dp #(
  parameter int NUM_TYPES  = 64,
  parameter int FIRST_TYPE = 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [setm_pkg::STAMP_W-1:0]      order_mask,
  input  logic [setm_pkg::MODE_W-1:0]       in_mode,
  input  logic [setm_pkg::S_TDATA_W-1:0]    in_data,
  input  setm_pkg::cmd_t                    cmd,
  output setm_pkg::status_t                 status,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [setm_pkg::M_TDATA_W-1:0]    m_tdata,
  output logic [setm_pkg::M_TUSER_W-1:0]    m_tuser
);
  import setm_pkg::*;

  localparam int IDX_W = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;

  // Captured item.
  logic [MODE_W-1:0]  mode;
  logic [TYPE_W-1:0]  stype;
  logic [STAMP_W-1:0] stamp;
  logic [STAMP_W-1:0] new_period;

  // Statistics memory with one fill bit per entry.
  stat_rec_t            mem [NUM_TYPES];
  logic [NUM_TYPES-1:0] filled;
  stat_rec_t            rd_raw;
  logic                 rd_filled;
  stat_rec_t            rec;

  // Jitter arithmetic.
  logic [STAMP_W-1:0] delta;
  logic [STAMP_W-1:0] dev;
  logic [STAMP_W-1:0] prod;
  logic [STAMP_W-1:0] sq;
  logic [HALF_W-1:0]  mul_a;

  // Update logic.
  logic               in_range;
  logic               accepted;
  logic               primed;
  stat_rec_t          upd;
  logic [IDX_W-1:0]   addr;
  logic [IDX_W-1:0]   in_addr;

  assign in_addr = in_data[IDX_W-1:0];
  assign addr    = stype[IDX_W-1:0];

  // Capture the word and read the type's entry at the same edge.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode       <= in_mode;
      stype      <= in_data[TYPE_W-1:0];
      stamp      <= in_data[TYPE_W +: STAMP_W];
      new_period <= in_data[TYPE_W+STAMP_W +: STAMP_W];
      rd_raw     <= mem[in_addr];
      rd_filled  <= filled[in_addr];
    end
  end

  assign rec = rd_filled ? rd_raw : REC_RESET;

  // Memory write on commit.
  always_ff @(posedge clk) begin
    if (cmd.commit && accepted) begin
      mem[addr] <= upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
    end else if (cmd.commit && accepted) begin
      filled[addr] <= 1'b1;
    end
  end

  // Timestamp delta, then absolute deviation from the expected period.
  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      delta <= stamp - rec.prev_stamp;
    end
    if (cmd.deviate) begin
      dev <= (delta > rec.period) ? delta - rec.period : rec.period - delta;
    end
  end

  // Square of the deviation, low 64 bits, on one shared 32x32 multiplier:
  // lo*lo plus twice hi*lo shifted up by 32.
  assign mul_a = cmd.mul_hi ? dev[STAMP_W-1:HALF_W] : dev[HALF_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.mul_lo || cmd.mul_hi) begin
      prod <= {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, dev[HALF_W-1:0]};
    end
    if (cmd.mul_hi) begin
      sq <= prod;
    end else if (cmd.sq_sum) begin
      sq <= sq + {prod[HALF_W-2:0], {(HALF_W+1){1'b0}}};
    end
  end

  assign in_range = ({1'b0, stype} < (TYPE_W+1)'(NUM_TYPES));

  // The jitter path needs the multiply sequence only when it measures.
  assign status.jitter_math = in_range && (mode == MODE_JITTER)
                              && (stype >= TYPE_W'(FIRST_TYPE))
                              && (rec.prev_stamp != '0);
  assign status.out_free    = !m_tvalid || m_tready;

  // New statistics of the type.
  always_comb begin
    upd      = rec;
    accepted = 1'b0;
    primed   = 1'b0;
    case (mode)
      MODE_LOAD: begin
        accepted   = in_range;
        upd.period = new_period;
      end
      MODE_CLEAR: begin
        accepted   = in_range;
        upd        = REC_RESET;
        upd.period = rec.period;
      end
      MODE_COMM: begin
        accepted       = in_range;
        upd.comm_count = rec.comm_count + CNT_W'(1);
      end
      MODE_JITTER: begin
        accepted = in_range && (stype >= TYPE_W'(FIRST_TYPE));
        if (rec.prev_stamp == '0) begin
          primed = 1'b1;
        end else begin
          if (dev < rec.min_dev) upd.min_dev = dev;
          if (dev > rec.max_dev) upd.max_dev = dev;
          upd.square_sum  = rec.square_sum + sq;
          upd.event_count = rec.event_count + CNT_W'(1);
        end
        upd.prev_stamp = stamp;
      end
      MODE_ORDER: begin
        accepted = in_range && order_mask[stype];
        if ((rec.prev_stamp == '0) || (stamp == '0)) begin
          primed = 1'b1;
        end else begin
          if (rec.prev_stamp >= stamp) begin
            upd.last_reversed = stamp;
            upd.order_fails   = rec.order_fails + CNT_W'(1);
          end
          upd.order_count = rec.order_count + CNT_W'(1);
        end
        upd.prev_stamp = stamp;
      end
      default: begin
        accepted = 1'b0;
      end
    endcase
    if (!accepted) begin
      upd    = rec;
      primed = 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_tuser <= {primed, accepted};
      if (in_range) begin
        m_tdata <= {upd.comm_count, upd.last_reversed, upd.order_fails,
                    upd.order_count, upd.square_sum, upd.max_dev,
                    upd.min_dev, upd.event_count};
      end else begin
        m_tdata <= '0;
      end
    end
  end

endmodule

// File: rtl/sensor_event_timing_monitor.sv
// Top level of the sensor event timing monitor: mask register, sequencer
// and datapath. Depends on setm_pkg, setm_ctrl and setm_dp.
//
//  channel   direction  contents
//  s_axis    in         tuser: mode; tdata: sensor_type, timestamp, period
//  m_axis    out        tuser: accepted, primed_only; tdata: statistics
//  cfg       in         order_type_mask write
//
// Words other than a measured jitter event pass through entry read, lookup and
// commit from one accept to the next; a measured jitter word also takes the
// deviation and two passes through the shared 32x32 multiplier.
// Synchronous reset clears the sequencer, the mask, the output valid and the
// per-type fill bits, so an unwritten entry reads as its reset statistics.
// A new word is taken while a result waits; only the commit step stalls on m_tready.
module sensor_event_timing_monitor #(
  parameter int NUM_TYPES  = 64,
  parameter int FIRST_TYPE = 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [setm_pkg::STAMP_W-1:0]      cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [2:0] mode
  input  logic [setm_pkg::MODE_W-1:0]       s_tuser,
  // [5:0] sensor_type, [69:6] timestamp, [133:70] expected_period_ns
  input  logic [setm_pkg::S_TDATA_W-1:0]    s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [0] accepted, [1] primed_only
  output logic [setm_pkg::M_TUSER_W-1:0]    m_tuser,
  // [31:0] event_count, [95:32] min_deviation, [159:96] max_deviation,
  // [223:160] square_sum, [255:224] order_count, [287:256] order_fails,
  // [351:288] last_reversed, [383:352] comm_count
  output logic [setm_pkg::M_TDATA_W-1:0]    m_tdata
);
  import setm_pkg::*;

  logic [STAMP_W-1:0] order_mask;
  cmd_t               cmd;
  status_t            status;

  // Order checking mask register.
  always_ff @(posedge clk) begin
    if (rst) begin
      order_mask <= '0;
    end else if (cfg_we) begin
      order_mask <= cfg_data;
    end
  end

  setm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  setm_dp #(
    .NUM_TYPES  (NUM_TYPES),
    .FIRST_TYPE (FIRST_TYPE)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .order_mask (order_mask),
    .in_mode    (s_tuser),
    .in_data    (s_tdata),
    .cmd        (cmd),
    .status     (status),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule
